// ----- rtl/mppt_pkg.sv -----
// shared types and constants for the duty sweep peak tracker
package mppt_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int DUTY_BITS   = 10;
  localparam int SCALE_BITS  = 16;
  localparam int SCALE_FRAC  = 12;
  localparam int COUNT_BITS  = 16;
  localparam int MEAN_BITS   = 16;
  localparam int SUM_BITS    = 32;
  localparam int POWER_BITS  = 32;
  localparam int MUL_BITS    = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VOLTAGE_SCALE    = 3'd0,
    REG_CURRENT_SCALE    = 3'd1,
    REG_OVERSAMPLE_COUNT = 3'd2,
    REG_DUTY_FLOOR       = 3'd3,
    REG_DUTY_CEILING     = 3'd4,
    REG_DUTY_INCREMENT   = 3'd5
  } cfg_reg_t;

  localparam logic [SCALE_BITS-1:0] VOLTAGE_SCALE_RST    = 16'd4096;
  localparam logic [SCALE_BITS-1:0] CURRENT_SCALE_RST    = 16'd4096;
  localparam logic [COUNT_BITS-1:0] OVERSAMPLE_COUNT_RST = 16'd1;
  localparam logic [DUTY_BITS-1:0]  DUTY_FLOOR_RST       = DUTY_BITS'(51);
  localparam logic [DUTY_BITS-1:0]  DUTY_CEILING_RST     = DUTY_BITS'(922);
  localparam logic [DUTY_BITS-1:0]  DUTY_INCREMENT_RST   = DUTY_BITS'(10);

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_START  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_V,
    S_MUL_C,
    S_ACC,
    S_DIV_V,
    S_DIV_C,
    S_MUL_P,
    S_UPDATE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic                   kind;
    logic [SAMPLE_BITS-1:0] voltage_sample;
    logic [SAMPLE_BITS-1:0] current_sample;
  } in_word_t;

  typedef struct packed {
    logic [DUTY_BITS-1:0]  measured_duty;
    logic [DUTY_BITS-1:0]  next_duty;
    logic [MEAN_BITS-1:0]  mean_voltage;
    logic [MEAN_BITS-1:0]  mean_current;
    logic [POWER_BITS-1:0] point_power;
    logic                  new_peak;
    logic [DUTY_BITS-1:0]  best_duty;
    logic [POWER_BITS-1:0] best_power;
    logic                  sweep_done;
  } out_word_t;

endpackage

// ----- rtl/mppt_div.sv -----
// serial restoring divider, one quotient bit per cycle, quotient saturates at 16 bits
module mppt_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [mppt_pkg::SUM_BITS-1:0]      dividend,
  input  logic [mppt_pkg::COUNT_BITS-1:0]    divisor,
  output logic                               done,
  output logic [mppt_pkg::MEAN_BITS-1:0]     quotient
);

  localparam int QW = mppt_pkg::MEAN_BITS;
  localparam int CW = $clog2(QW);

  logic          busy;
  logic [CW-1:0] count;
  logic [QW-1:0] rem;
  logic [QW-1:0] work;
  logic [QW+1:0] diff;
  logic          fits;
  logic          sat;

  assign diff     = {1'b0, rem, work[QW-1]} - {2'b00, divisor};
  assign fits     = ~diff[QW+1];
  // quotient cannot fit in 16 bits when the upper half already reaches the divisor
  assign sat      = dividend[mppt_pkg::SUM_BITS-1 -: QW] >= divisor;
  assign quotient = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (sat) begin
          done <= 1'b1;
        end else begin
          busy  <= 1'b1;
          count <= CW'(QW - 1);
        end
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      if (sat) begin
        work <= '1;
      end else begin
        rem  <= dividend[mppt_pkg::SUM_BITS-1 -: QW];
        work <= dividend[QW-1:0];
      end
    end else if (busy) begin
      rem  <= fits ? diff[QW-1:0] : {rem[QW-2:0], work[QW-1]};
      work <= {work[QW-2:0], fits};
    end
  end

endmodule

// ----- rtl/mppt_duty_sweep_peak_tracker.sv -----
// top level: sequencer, shared multiplier, sums, peak record and output register
// Sweep-based maximum power point search. A start word clears the peak record, sums and tally
// and sets the duty to the floor (the ceiling if the floor lies above it); the tracker stays
// ready for the next word. During a sweep, a sample word scales both codes with one shared
// 16x16 multiplier and adds them to saturating sums; samples outside a sweep are dropped.
// When the tally reaches the oversample count, the two means come in turn from one shared
// serial divider (a mean that would overflow saturates to all ones), the multiplier then
// forms the power, and the peak and duty step are updated. in_ready is low while a word is
// in work; a finished result waits in the output register, and the next word is accepted meanwhile.
module mppt_duty_sweep_peak_tracker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mppt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mppt_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  mppt_pkg::in_word_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output mppt_pkg::out_word_t                 out_data
);

  localparam int DW = mppt_pkg::DUTY_BITS;
  localparam int SW = mppt_pkg::SUM_BITS;
  localparam int PW = mppt_pkg::POWER_BITS;
  localparam int MW = mppt_pkg::MUL_BITS;
  localparam int NW = mppt_pkg::COUNT_BITS;

  // configuration
  logic [mppt_pkg::SCALE_BITS-1:0] voltage_scale;
  logic [mppt_pkg::SCALE_BITS-1:0] current_scale;
  logic [NW-1:0]                   oversample_count;
  logic [DW-1:0]                   duty_floor;
  logic [DW-1:0]                   duty_ceiling;
  logic [DW-1:0]                   duty_increment;

  // tracker state
  logic [DW-1:0] duty_now;
  logic [SW-1:0] voltage_sum;
  logic [SW-1:0] current_sum;
  logic [NW-1:0] sample_tally;
  logic [PW-1:0] peak_power;
  logic [DW-1:0] peak_duty;
  logic          sweeping;

  mppt_pkg::state_t state, state_next;

  // working registers
  logic [mppt_pkg::SAMPLE_BITS-1:0] v_code;
  logic [mppt_pkg::SAMPLE_BITS-1:0] c_code;
  logic [mppt_pkg::MEAN_BITS-1:0]   mean_v;
  logic [mppt_pkg::MEAN_BITS-1:0]   mean_c;
  logic [2*MW-1:0]                  prod;
  mppt_pkg::out_word_t              result;

  logic                  in_fire;
  logic                  out_free;
  logic [MW-1:0]         mul_a;
  logic [MW-1:0]         mul_b;
  logic [SW-1:0]         scaled;
  logic [SW:0]           sum_add;
  logic [SW-1:0]         sum_sat;
  logic [SW-1:0]         sum_in;
  logic [NW-1:0]         n_eff;
  logic [NW-1:0]         tally_inc;
  logic                  avg_done;
  logic                  div_start;
  logic                  div_done;
  logic [SW-1:0]         div_dividend;
  logic [mppt_pkg::MEAN_BITS-1:0] div_q;
  logic [DW-1:0]         inc_eff;
  logic [DW:0]           step_sum;
  logic [DW:0]           step_lo;
  logic [DW-1:0]         step_duty;
  logic [DW-1:0]         start_duty;
  logic                  step_end;
  logic                  is_peak;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == mppt_pkg::S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  assign n_eff     = (oversample_count == '0) ? NW'(1) : oversample_count;
  assign tally_inc = sample_tally + 1'b1;
  assign avg_done  = (tally_inc == '0) || (tally_inc >= n_eff);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      mppt_pkg::S_MUL_V: begin
        mul_a = MW'(v_code);
        mul_b = voltage_scale;
      end
      mppt_pkg::S_MUL_C: begin
        mul_a = MW'(c_code);
        mul_b = current_scale;
      end
      mppt_pkg::S_MUL_P: begin
        mul_a = mean_v;
        mul_b = mean_c;
      end
      default: begin
      end
    endcase
  end

  // one saturating accumulator, voltage in the cycle after the voltage product, then current
  assign scaled  = SW'(prod[2*MW-1:mppt_pkg::SCALE_FRAC]);
  assign sum_in  = (state == mppt_pkg::S_MUL_C) ? voltage_sum : current_sum;
  assign sum_add = {1'b0, sum_in} + {1'b0, scaled};
  assign sum_sat = sum_add[SW] ? '1 : sum_add[SW-1:0];

  assign div_start    = ((state == mppt_pkg::S_ACC) && avg_done) ||
                        ((state == mppt_pkg::S_DIV_V) && div_done);
  assign div_dividend = (state == mppt_pkg::S_ACC) ? voltage_sum : current_sum;

  mppt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (n_eff),
    .done     (div_done),
    .quotient (div_q)
  );

  // duty step: raise to floor, then lower to ceiling
  assign inc_eff    = (duty_increment == '0) ? DW'(1) : duty_increment;
  assign step_sum   = {1'b0, duty_now} + {1'b0, inc_eff};
  assign step_lo    = (step_sum < {1'b0, duty_floor}) ? {1'b0, duty_floor} : step_sum;
  assign step_duty  = (step_lo > {1'b0, duty_ceiling}) ? duty_ceiling : step_lo[DW-1:0];
  assign step_end   = step_sum >= {1'b0, duty_ceiling};
  assign start_duty = (duty_floor > duty_ceiling) ? duty_ceiling : duty_floor;
  assign is_peak    = prod > peak_power;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mppt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mppt_pkg::S_IDLE: begin
        if (in_fire && in_data.kind == mppt_pkg::KIND_SAMPLE && sweeping) begin
          state_next = mppt_pkg::S_MUL_V;
        end
      end
      mppt_pkg::S_MUL_V:  state_next = mppt_pkg::S_MUL_C;
      mppt_pkg::S_MUL_C:  state_next = mppt_pkg::S_ACC;
      mppt_pkg::S_ACC:    state_next = avg_done ? mppt_pkg::S_DIV_V : mppt_pkg::S_IDLE;
      mppt_pkg::S_DIV_V: begin
        if (div_done) state_next = mppt_pkg::S_DIV_C;
      end
      mppt_pkg::S_DIV_C: begin
        if (div_done) state_next = mppt_pkg::S_MUL_P;
      end
      mppt_pkg::S_MUL_P:  state_next = mppt_pkg::S_UPDATE;
      mppt_pkg::S_UPDATE: state_next = mppt_pkg::S_FINISH;
      mppt_pkg::S_FINISH: begin
        if (out_free) state_next = mppt_pkg::S_IDLE;
      end
      default:            state_next = mppt_pkg::S_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      voltage_scale    <= mppt_pkg::VOLTAGE_SCALE_RST;
      current_scale    <= mppt_pkg::CURRENT_SCALE_RST;
      oversample_count <= mppt_pkg::OVERSAMPLE_COUNT_RST;
      duty_floor       <= mppt_pkg::DUTY_FLOOR_RST;
      duty_ceiling     <= mppt_pkg::DUTY_CEILING_RST;
      duty_increment   <= mppt_pkg::DUTY_INCREMENT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mppt_pkg::REG_VOLTAGE_SCALE:    voltage_scale    <= cfg_data;
        mppt_pkg::REG_CURRENT_SCALE:    current_scale    <= cfg_data;
        mppt_pkg::REG_OVERSAMPLE_COUNT: oversample_count <= cfg_data;
        mppt_pkg::REG_DUTY_FLOOR:       duty_floor       <= cfg_data[DW-1:0];
        mppt_pkg::REG_DUTY_CEILING:     duty_ceiling     <= cfg_data[DW-1:0];
        mppt_pkg::REG_DUTY_INCREMENT:   duty_increment   <= cfg_data[DW-1:0];
        default: begin
        end
      endcase
    end
  end

  // tracker state
  always_ff @(posedge clk) begin
    if (rst) begin
      duty_now     <= '0;
      voltage_sum  <= '0;
      current_sum  <= '0;
      sample_tally <= '0;
      peak_power   <= '0;
      peak_duty    <= '0;
      sweeping     <= 1'b0;
    end else begin
      if (in_fire && in_data.kind == mppt_pkg::KIND_START) begin
        peak_power   <= '0;
        peak_duty    <= '0;
        voltage_sum  <= '0;
        current_sum  <= '0;
        sample_tally <= '0;
        duty_now     <= start_duty;
        sweeping     <= 1'b1;
      end
      if (state == mppt_pkg::S_MUL_C) begin
        voltage_sum <= sum_sat;
      end
      if (state == mppt_pkg::S_ACC) begin
        current_sum  <= sum_sat;
        sample_tally <= tally_inc;
      end
      if (state == mppt_pkg::S_UPDATE) begin
        if (is_peak) begin
          peak_power <= prod;
          peak_duty  <= duty_now;
        end
        duty_now     <= step_duty;
        voltage_sum  <= '0;
        current_sum  <= '0;
        sample_tally <= '0;
        if (step_end) sweeping <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= (2*MW)'(mul_a) * (2*MW)'(mul_b);
    if (in_fire) begin
      v_code <= in_data.voltage_sample;
      c_code <= in_data.current_sample;
    end
    if (state == mppt_pkg::S_DIV_V && div_done) mean_v <= div_q;
    if (state == mppt_pkg::S_DIV_C && div_done) mean_c <= div_q;
    if (state == mppt_pkg::S_UPDATE) begin
      result.measured_duty <= duty_now;
      result.next_duty     <= step_duty;
      result.mean_voltage  <= mean_v;
      result.mean_current  <= mean_c;
      result.point_power   <= prod;
      result.new_peak      <= is_peak;
      result.best_duty     <= is_peak ? duty_now : peak_duty;
      result.best_power    <= is_peak ? prod : peak_power;
      result.sweep_done    <= step_end;
    end
    if (state == mppt_pkg::S_FINISH && out_free) begin
      out_data <= result;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == mppt_pkg::S_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- rtl/mppt_sva.sv -----
// port-level checks for the duty sweep peak tracker, bound to the top level
module mppt_sva (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input mppt_pkg::in_word_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input mppt_pkg::out_word_t out_data
);

  // a waiting result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // in_ready is still high in the cycle after a start word is taken
  a_start_quick: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.kind == mppt_pkg::KIND_START |=> in_ready)
    else $error("start word kept the tracker busy");

  a_peak_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.best_power >= out_data.point_power)
    else $error("point power above recorded peak");

  a_peak_record: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.new_peak |->
      out_data.best_duty == out_data.measured_duty &&
      out_data.best_power == out_data.point_power)
    else $error("new peak not recorded");

  a_power: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.point_power ==
      mppt_pkg::POWER_BITS'(out_data.mean_voltage) *
      mppt_pkg::POWER_BITS'(out_data.mean_current))
    else $error("power is not the product of the means");

endmodule

bind mppt_duty_sweep_peak_tracker mppt_sva u_mppt_sva (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- tb/tb_mppt_duty_sweep_peak_tracker.sv -----
// self-checking testbench for the duty sweep peak tracker
module tb_mppt_duty_sweep_peak_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 60;
  localparam int STALL_LIMIT   = 3000;
  localparam int SHOWN_LIMIT   = 10;
  localparam int PROD_W        = mppt_pkg::SAMPLE_BITS + mppt_pkg::SCALE_BITS;
  localparam int WIDE_W        = mppt_pkg::SUM_BITS + 1;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [mppt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [mppt_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
  logic                            in_valid  = 1'b0;
  logic                            in_ready;
  mppt_pkg::in_word_t              in_data   = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b1;
  mppt_pkg::out_word_t             out_data;

  mppt_duty_sweep_peak_tracker DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // tracker mirror: register copies
  logic [mppt_pkg::SCALE_BITS-1:0] cfg_vscale = mppt_pkg::VOLTAGE_SCALE_RST;
  logic [mppt_pkg::SCALE_BITS-1:0] cfg_iscale = mppt_pkg::CURRENT_SCALE_RST;
  logic [mppt_pkg::COUNT_BITS-1:0] cfg_navg   = mppt_pkg::OVERSAMPLE_COUNT_RST;
  logic [mppt_pkg::DUTY_BITS-1:0]  cfg_floor  = mppt_pkg::DUTY_FLOOR_RST;
  logic [mppt_pkg::DUTY_BITS-1:0]  cfg_ceil   = mppt_pkg::DUTY_CEILING_RST;
  logic [mppt_pkg::DUTY_BITS-1:0]  cfg_stride = mppt_pkg::DUTY_INCREMENT_RST;

  // tracker mirror: sweep state
  logic [mppt_pkg::DUTY_BITS-1:0]  cur_duty = '0;
  logic [mppt_pkg::SUM_BITS-1:0]   v_acc    = '0;
  logic [mppt_pkg::SUM_BITS-1:0]   i_acc    = '0;
  logic [mppt_pkg::COUNT_BITS-1:0] pair_cnt = '0;
  logic [mppt_pkg::POWER_BITS-1:0] pk_power = '0;
  logic [mppt_pkg::DUTY_BITS-1:0]  pk_duty  = '0;
  bit                              in_sweep = 1'b0;

  mppt_pkg::out_word_t pending_points[$];

  bit gaps_on = 1'b1;
  bit calm    = 1'b0;
  int mismatches     = 0;
  int words_sent     = 0;
  int starts_sent    = 0;
  int points_checked = 0;
  int peaks_seen     = 0;
  int sweeps_ended   = 0;
  int settings_used  = 0;

  initial begin : clock_gen
    forever #6 clk = ~clk;
  end

  function automatic logic [mppt_pkg::DUTY_BITS-1:0] limit_duty(
      input logic [mppt_pkg::DUTY_BITS:0] d);
    if (d < {1'b0, cfg_floor}) d = {1'b0, cfg_floor};
    if (d > {1'b0, cfg_ceil}) d = {1'b0, cfg_ceil};
    return d[mppt_pkg::DUTY_BITS-1:0];
  endfunction

  // advances the mirror by one word; returns 1 when an averaged point comes out
  function automatic bit compute_point(input mppt_pkg::in_word_t w,
                                       output mppt_pkg::out_word_t pt);
    logic [PROD_W-1:0]                 v_scaled, i_scaled;
    logic [WIDE_W-1:0]                 v_wide, i_wide;
    logic [mppt_pkg::COUNT_BITS-1:0]   navg;
    logic [mppt_pkg::SUM_BITS-1:0]     v_mean, i_mean;
    logic [mppt_pkg::POWER_BITS-1:0]   pwr;
    logic [mppt_pkg::DUTY_BITS:0]      stride, stepped;
    logic [mppt_pkg::DUTY_BITS-1:0]    here;
    pt = '0;
    if (w.kind == mppt_pkg::KIND_START) begin
      pk_power = '0;
      pk_duty  = '0;
      v_acc    = '0;
      i_acc    = '0;
      pair_cnt = '0;
      cur_duty = limit_duty({1'b0, cfg_floor});
      in_sweep = 1'b1;
      return 1'b0;
    end
    if (!in_sweep) return 1'b0;

    v_scaled = PROD_W'(w.voltage_sample) * PROD_W'(cfg_vscale);
    i_scaled = PROD_W'(w.current_sample) * PROD_W'(cfg_iscale);
    v_wide   = {1'b0, v_acc} + WIDE_W'(v_scaled[PROD_W-1:mppt_pkg::SCALE_FRAC]);
    i_wide   = {1'b0, i_acc} + WIDE_W'(i_scaled[PROD_W-1:mppt_pkg::SCALE_FRAC]);
    v_acc    = v_wide[mppt_pkg::SUM_BITS] ? '1 : v_wide[mppt_pkg::SUM_BITS-1:0];
    i_acc    = i_wide[mppt_pkg::SUM_BITS] ? '1 : i_wide[mppt_pkg::SUM_BITS-1:0];
    pair_cnt = pair_cnt + 1'b1;

    navg = (cfg_navg == '0) ? mppt_pkg::COUNT_BITS'(1) : cfg_navg;
    if (pair_cnt != '0 && pair_cnt < navg) return 1'b0;

    v_mean = v_acc / mppt_pkg::SUM_BITS'(navg);
    i_mean = i_acc / mppt_pkg::SUM_BITS'(navg);
    if (v_mean > 32'd65535) v_mean = 32'd65535;
    if (i_mean > 32'd65535) i_mean = 32'd65535;
    pwr  = mppt_pkg::POWER_BITS'(v_mean[mppt_pkg::MEAN_BITS-1:0]) *
           mppt_pkg::POWER_BITS'(i_mean[mppt_pkg::MEAN_BITS-1:0]);
    here = cur_duty;

    pt.new_peak = 1'b0;
    if (pwr > pk_power) begin
      pk_power    = pwr;
      pk_duty     = here;
      pt.new_peak = 1'b1;
    end

    stride        = (cfg_stride == '0) ? (mppt_pkg::DUTY_BITS+1)'(1) : {1'b0, cfg_stride};
    stepped       = {1'b0, here} + stride;
    pt.sweep_done = (stepped >= {1'b0, cfg_ceil});
    cur_duty      = limit_duty(stepped);
    if (pt.sweep_done) in_sweep = 1'b0;
    v_acc    = '0;
    i_acc    = '0;
    pair_cnt = '0;

    pt.measured_duty = here;
    pt.next_duty     = cur_duty;
    pt.mean_voltage  = v_mean[mppt_pkg::MEAN_BITS-1:0];
    pt.mean_current  = i_mean[mppt_pkg::MEAN_BITS-1:0];
    pt.point_power   = pwr;
    pt.best_duty     = pk_duty;
    pt.best_power    = pk_power;
    return 1'b1;
  endfunction

  function automatic logic [mppt_pkg::SAMPLE_BITS-1:0] rand_code();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return mppt_pkg::SAMPLE_BITS'($urandom_range(0,
                                             (1 << mppt_pkg::SAMPLE_BITS) - 1));
    endcase
  endfunction

  function automatic mppt_pkg::in_word_t sample_word(
      input logic [mppt_pkg::SAMPLE_BITS-1:0] v,
      input logic [mppt_pkg::SAMPLE_BITS-1:0] i);
    mppt_pkg::in_word_t w;
    w.kind           = mppt_pkg::KIND_SAMPLE;
    w.voltage_sample = v;
    w.current_sample = i;
    return w;
  endfunction

  // start word with junk in the sample fields, which the block must ignore
  function automatic mppt_pkg::in_word_t start_word();
    mppt_pkg::in_word_t w;
    w.kind           = mppt_pkg::KIND_START;
    w.voltage_sample = rand_code();
    w.current_sample = rand_code();
    return w;
  endfunction

  function automatic logic [mppt_pkg::CFG_DATA_W-1:0] rand_val(input int lo, input int hi);
    return mppt_pkg::CFG_DATA_W'($urandom_range(lo, hi));
  endfunction

  task automatic send_word(input mppt_pkg::in_word_t w);
    mppt_pkg::out_word_t pt;
    if (gaps_on && !calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    if (w.kind == mppt_pkg::KIND_START) starts_sent++;
    if (compute_point(w, pt)) pending_points.push_back(pt);
  endtask

  // hold keeps cfg_valid up for a following write
  task automatic write_reg(input mppt_pkg::cfg_reg_t idx,
                           input logic [mppt_pkg::CFG_DATA_W-1:0] val,
                           input bit hold);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (!hold) begin
      cfg_valid <= 1'b0;
      settings_used++;
    end
    case (idx)
      mppt_pkg::REG_VOLTAGE_SCALE:    cfg_vscale = val;
      mppt_pkg::REG_CURRENT_SCALE:    cfg_iscale = val;
      mppt_pkg::REG_OVERSAMPLE_COUNT: cfg_navg   = val;
      mppt_pkg::REG_DUTY_FLOOR:       cfg_floor  = val[mppt_pkg::DUTY_BITS-1:0];
      mppt_pkg::REG_DUTY_CEILING:     cfg_ceil   = val[mppt_pkg::DUTY_BITS-1:0];
      mppt_pkg::REG_DUTY_INCREMENT:   cfg_stride = val[mppt_pkg::DUTY_BITS-1:0];
      default: ;
    endcase
  endtask

  // drain all pending points, then let a partial average finish its work
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_idle_samples();
    send_word(sample_word('1, '1));
    send_word(sample_word('0, '0));
    settle();
  endtask

  task automatic test_field_extremes();
    send_word(start_word());
    send_word(sample_word('0, '0));
    send_word(sample_word('1, '1));
    send_word(sample_word('1, '0));
    send_word(sample_word('0, '1));
    send_word(sample_word(12'h800, 12'h001));
    send_word(start_word());
    send_word(sample_word(12'h001, '1));
    settle();
  endtask

  task automatic test_count_and_overflow();
    write_reg(mppt_pkg::REG_VOLTAGE_SCALE, '1, 1'b1);
    write_reg(mppt_pkg::REG_CURRENT_SCALE, '1, 1'b1);
    write_reg(mppt_pkg::REG_OVERSAMPLE_COUNT, '1, 1'b0);
    send_word(start_word());
    repeat (3) send_word(sample_word('1, '1));
    settle();
    // lowered count completes at once and the means saturate
    write_reg(mppt_pkg::REG_OVERSAMPLE_COUNT, 16'd1, 1'b0);
    send_word(sample_word('1, '1));
    settle();
    write_reg(mppt_pkg::REG_OVERSAMPLE_COUNT, 16'd0, 1'b0);
    send_word(sample_word(12'd100, '1));
    settle();
    write_reg(mppt_pkg::REG_VOLTAGE_SCALE, '0, 1'b1);
    write_reg(mppt_pkg::REG_CURRENT_SCALE, mppt_pkg::CURRENT_SCALE_RST, 1'b0);
    send_word(sample_word('1, '1));
    settle();
  endtask

  task automatic test_duty_limits();
    write_reg(mppt_pkg::REG_VOLTAGE_SCALE, mppt_pkg::VOLTAGE_SCALE_RST, 1'b1);
    write_reg(mppt_pkg::REG_DUTY_FLOOR, 16'd1023, 1'b1);
    write_reg(mppt_pkg::REG_DUTY_CEILING, 16'd0, 1'b0);
    send_word(start_word());
    send_word(sample_word(12'd700, 12'd900));
    settle();
    write_reg(mppt_pkg::REG_DUTY_FLOOR, 16'd0, 1'b1);
    write_reg(mppt_pkg::REG_DUTY_CEILING, 16'd1023, 1'b1);
    write_reg(mppt_pkg::REG_DUTY_INCREMENT, 16'd0, 1'b0);
    send_word(start_word());
    send_word(sample_word(12'd300, 12'd200));
    send_word(sample_word(12'd301, 12'd200));
    settle();
    write_reg(mppt_pkg::REG_DUTY_INCREMENT, 16'd1023, 1'b0);
    send_word(sample_word(12'd3000, 12'd3000));
    settle();
  endtask

  task automatic test_random_sweeps(input int phases, input int words_per_phase);
    int counted;
    int pick;
    for (int p = 0; p < phases; p++) begin
      settle();
      calm    = (p == phases - 1);
      gaps_on = (p % 3 != 1);
      case ($urandom_range(0, 5))
        0:       write_reg(mppt_pkg::REG_VOLTAGE_SCALE, '0, 1'b1);
        1:       write_reg(mppt_pkg::REG_VOLTAGE_SCALE, '1, 1'b1);
        2:       write_reg(mppt_pkg::REG_VOLTAGE_SCALE, mppt_pkg::VOLTAGE_SCALE_RST, 1'b1);
        default: write_reg(mppt_pkg::REG_VOLTAGE_SCALE, rand_val(0, 65535), 1'b1);
      endcase
      case ($urandom_range(0, 5))
        0:       write_reg(mppt_pkg::REG_CURRENT_SCALE, '0, 1'b1);
        1:       write_reg(mppt_pkg::REG_CURRENT_SCALE, '1, 1'b1);
        2:       write_reg(mppt_pkg::REG_CURRENT_SCALE, mppt_pkg::CURRENT_SCALE_RST, 1'b1);
        default: write_reg(mppt_pkg::REG_CURRENT_SCALE, rand_val(0, 65535), 1'b1);
      endcase
      case ($urandom_range(0, 5))
        0:       write_reg(mppt_pkg::REG_OVERSAMPLE_COUNT, 16'd0, 1'b1);
        1:       write_reg(mppt_pkg::REG_OVERSAMPLE_COUNT, 16'd1, 1'b1);
        2:       write_reg(mppt_pkg::REG_OVERSAMPLE_COUNT, rand_val(8, 24), 1'b1);
        default: write_reg(mppt_pkg::REG_OVERSAMPLE_COUNT, rand_val(1, 4), 1'b1);
      endcase
      case ($urandom_range(0, 5))
        0:       write_reg(mppt_pkg::REG_DUTY_FLOOR, 16'd0, 1'b1);
        1:       write_reg(mppt_pkg::REG_DUTY_FLOOR, 16'd1023, 1'b1);
        default: write_reg(mppt_pkg::REG_DUTY_FLOOR, rand_val(0, 600), 1'b1);
      endcase
      case ($urandom_range(0, 5))
        0:       write_reg(mppt_pkg::REG_DUTY_CEILING, 16'd1023, 1'b1);
        1:       write_reg(mppt_pkg::REG_DUTY_CEILING, 16'd0, 1'b1);
        default: write_reg(mppt_pkg::REG_DUTY_CEILING, rand_val(300, 1023), 1'b1);
      endcase
      case ($urandom_range(0, 5))
        0:       write_reg(mppt_pkg::REG_DUTY_INCREMENT, 16'd0, 1'b0);
        1:       write_reg(mppt_pkg::REG_DUTY_INCREMENT, 16'd1, 1'b0);
        2:       write_reg(mppt_pkg::REG_DUTY_INCREMENT, 16'd1023, 1'b0);
        default: write_reg(mppt_pkg::REG_DUTY_INCREMENT, rand_val(16, 200), 1'b0);
      endcase

      counted = 0;
      while (counted < words_per_phase) begin
        pick = $urandom_range(0, 199);
        if (!in_sweep) begin
          // samples between sweeps are dropped by the block and not counted
          if (pick < 40) begin
            send_word(sample_word(rand_code(), rand_code()));
          end else begin
            send_word(start_word());
            counted++;
          end
        end else if (pick < 6) begin
          send_word(start_word());
          counted++;
        end else if (pick == 6) begin
          settle();
        end else begin
          send_word(sample_word(rand_code(), rand_code()));
          counted++;
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] seen);
    if (seen !== want) begin
      if (mismatches < SHOWN_LIMIT)
        $display("point %0d %s: expected %0d, got %0d", points_checked, name, want, seen);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_points
    mppt_pkg::out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_points.size() == 0) begin
        if (mismatches < SHOWN_LIMIT)
          $display("point %0d arrived with nothing pending: %h", points_checked, out_data);
        mismatches++;
      end else begin
        want = pending_points.pop_front();
        check_field("measured_duty", 32'(want.measured_duty), 32'(out_data.measured_duty));
        check_field("next_duty", 32'(want.next_duty), 32'(out_data.next_duty));
        check_field("mean_voltage", 32'(want.mean_voltage), 32'(out_data.mean_voltage));
        check_field("mean_current", 32'(want.mean_current), 32'(out_data.mean_current));
        check_field("point_power", want.point_power, out_data.point_power);
        check_field("new_peak", 32'(want.new_peak), 32'(out_data.new_peak));
        check_field("best_duty", 32'(want.best_duty), 32'(out_data.best_duty));
        check_field("best_power", want.best_power, out_data.best_power);
        check_field("sweep_done", 32'(want.sweep_done), 32'(out_data.sweep_done));
        if (want.new_peak) peaks_seen++;
        if (want.sweep_done) sweeps_ended++;
      end
      points_checked++;
    end
  end

  // result side back-pressure in random bursts
  initial begin : result_stalls
    forever begin
      @(posedge clk);
      if (gaps_on && !calm && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("no word moved for %0d cycles", STALL_LIMIT);
    $display("mppt_duty_sweep_peak_tracker: mismatch");
    $finish;
  end

  initial begin : run
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_samples();
    test_field_extremes();
    test_count_and_overflow();
    test_duty_limits();
    test_random_sweeps(9, 140);
    settle();
    $display("run covered %0d input words (%0d sweep starts) under %0d register settings",
             words_sent, starts_sent, settings_used);
    $display("checked %0d averaged points, %0d new peaks, %0d completed sweeps",
             points_checked, peaks_seen, sweeps_ended);
    if (mismatches == 0)
      $display("mppt_duty_sweep_peak_tracker: match");
    else
      $display("mppt_duty_sweep_peak_tracker: mismatch");
    $finish;
  end

endmodule
